// ===== hdl/nsvl_pkg.sv =====
// ----------------------------------------------------------------------------
// nsvl_pkg
// Shared types and constants for the nearest-seed voxel labeler.
// ----------------------------------------------------------------------------
package nsvl_pkg;

   localparam int COORD_W     = 20;   // Q4 millimetres
   localparam int DIFF_W      = 21;   // coordinate difference / magnitude
   localparam int SQ_W        = 41;   // one squared difference
   localparam int DIST_W      = 42;   // sum of three squares
   localparam int RAD_W       = 44;   // squared radius, Q8 mm^2
   localparam int SEED_CNT_W  = 5;
   localparam int SLOT_W      = 4;
   localparam int SLICE_CNT_W = 19;
   localparam int CSR_IDX_W   = 2;

   localparam logic [RAD_W-1:0] POS_RAD_RESET = 44'd6400;
   localparam logic [RAD_W-1:0] DC_RAD_RESET  = 44'd16384;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_VOXEL = 1'b1;

   localparam logic signed [1:0] LABEL_POS = 2'sb01;
   localparam logic signed [1:0] LABEL_BG  = 2'sb00;
   localparam logic signed [1:0] LABEL_DC  = 2'sb11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SEED_COUNT = 2'd0,
      CSR_POS_RAD    = 2'd1,
      CSR_DC_RAD     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      is_true;
   } seed_entry_type;

   // control that travels with a seed through the distance unit
   typedef struct packed {
      logic vld;
      logic last;
      logic is_true;
   } pipe_ctl_type;

endpackage

// ===== hdl/nsvl_if.sv =====
// ----------------------------------------------------------------------------
// nsvl_if
// Valid/ready channels of the labeler: request items in, result items out.
// ----------------------------------------------------------------------------
interface nsvl_req_if;
   logic                                valid;
   logic                                ready;
   logic                                kind;
   logic signed [nsvl_pkg::COORD_W-1:0] coord_x;
   logic signed [nsvl_pkg::COORD_W-1:0] coord_y;
   logic signed [nsvl_pkg::COORD_W-1:0] coord_z;
   logic [nsvl_pkg::SLOT_W-1:0]         slot;
   logic                                seed_true;
   logic                                slice_last;

   modport source (output valid, kind, coord_x, coord_y, coord_z, slot, seed_true,
                   slice_last, input ready);
   modport sink (input valid, kind, coord_x, coord_y, coord_z, slot, seed_true,
                 slice_last, output ready);
endinterface

interface nsvl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [1:0]                    label;
   logic                                 near_positive;
   logic                                 slice_done;
   logic                                 slice_kept;
   logic [nsvl_pkg::SLICE_CNT_W-1:0]     slice_negative_count;
   logic [nsvl_pkg::SLICE_CNT_W-1:0]     slice_positive_count;

   modport source (output valid, label, near_positive, slice_done, slice_kept,
                   slice_negative_count, slice_positive_count, input ready);
   modport sink (input valid, label, near_positive, slice_done, slice_kept,
                 slice_negative_count, slice_positive_count, output ready);
endinterface

// ===== hdl/nearest_seed_voxel_labeler.sv =====
// ----------------------------------------------------------------------------
// nearest_seed_voxel_labeler
// Labels voxels by their nearest seed point and keeps per-slice counts.
// ----------------------------------------------------------------------------
//   channel  | dir | handshake          | carries
//   req_ch   | in  | valid/ready        | load seed or classify voxel item
//   rsp_ch   | out | valid/ready        | label and slice summary, voxels only
//   csr_*    | in  | csr_we, no wait    | seed count and two squared radii
//
// A load item only writes the table. A voxel item holds off new items until its
// result is registered; it scans n = min(seed_count, MAX_SEEDS) seeds.
// An empty table skips the scan. The distance unit takes one seed per cycle
// during the scan, behind a registered table read and two internal stages.
// Reset is synchronous; the seed table is not cleared and must be loaded.
// Results wait in an output register; requests are taken again while it waits.
// ----------------------------------------------------------------------------
module nearest_seed_voxel_labeler #(
   parameter int MAX_SEEDS        = 16,
   parameter int MAX_SLICE_VOXELS = 262144
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [nsvl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nsvl_pkg::RAD_W-1:0]       csr_wdata,
   nsvl_req_if.sink                         req_ch,
   nsvl_rsp_if.source                       rsp_ch
);

   localparam int IDX_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
   localparam int CNT_W = $clog2(MAX_SEEDS + 1);
   localparam int SLC_W = $clog2(MAX_SLICE_VOXELS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } state_type;

   // configuration
   logic [nsvl_pkg::SEED_CNT_W-1:0] seed_count_ff;
   logic [nsvl_pkg::RAD_W-1:0]      pos_rad_ff, dc_rad_ff;

   // control
   state_type                       state_ff, state_in;
   logic [CNT_W-1:0]                n_ff, n_in;
   logic [CNT_W-1:0]                issue_cnt_ff;
   logic                            last_ff;
   logic signed [nsvl_pkg::COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;

   // seed table and read stage
   nsvl_pkg::seed_entry_type        seed_mem_ff [MAX_SEEDS];
   nsvl_pkg::seed_entry_type        seed_q_ff, wr_entry;
   nsvl_pkg::pipe_ctl_type          rd_ctl_ff, rd_ctl_in, dist_ctl_in, dist_ctl;
   logic [nsvl_pkg::DIST_W-1:0]     dist_sq;

   // running best
   logic [nsvl_pkg::DIST_W-1:0]     best_d_ff;
   logic                            best_true_ff, best_vld_ff;

   // slice state
   logic [SLC_W-1:0]                zero_cnt_ff, one_cnt_ff, zero_cnt_in, one_cnt_in;
   logic                            hit_ff, hit_in;

   // result register
   logic                            rsp_vld_ff;
   logic signed [1:0]               label_ff, label_in;
   logic                            near_ff, done_ff, kept_ff;
   logic [nsvl_pkg::SLICE_CNT_W-1:0] neg_cnt_ff, pos_cnt_ff;

   logic req_accept, voxel_accept, load_wr, issue, take, out_free, finish;
   logic near, in_dc, one_inc, zero_inc;
   logic [IDX_W-1:0] wr_addr;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign voxel_accept = req_accept && (req_ch.kind == nsvl_pkg::KIND_VOXEL);
   assign load_wr      = req_accept && (req_ch.kind == nsvl_pkg::KIND_LOAD)
                         && (32'(req_ch.slot) < MAX_SEEDS);
   assign wr_addr      = IDX_W'(req_ch.slot);
   assign wr_entry     = '{x: req_ch.coord_x, y: req_ch.coord_y, z: req_ch.coord_z,
                           is_true: req_ch.seed_true};

   assign n_in = (32'(seed_count_ff) > MAX_SEEDS) ? CNT_W'(MAX_SEEDS)
                                                  : CNT_W'(seed_count_ff);

   assign issue     = (state_ff == ST_SCAN) && (issue_cnt_ff < n_ff);
   assign rd_ctl_in = '{vld: issue, last: (issue_cnt_ff == n_ff - 1'b1), is_true: 1'b0};
   assign dist_ctl_in = '{vld: rd_ctl_ff.vld, last: rd_ctl_ff.last,
                          is_true: seed_q_ff.is_true};

   // strict less-than keeps the lowest slot on ties
   assign take     = dist_ctl.vld && (!best_vld_ff || (dist_sq < best_d_ff));
   assign out_free = !rsp_vld_ff || rsp_ch.ready;
   assign finish   = (state_ff == ST_DECIDE) && out_free;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_count_ff <= '0;
         pos_rad_ff    <= nsvl_pkg::POS_RAD_RESET;
         dc_rad_ff     <= nsvl_pkg::DC_RAD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            nsvl_pkg::CSR_SEED_COUNT: begin
               seed_count_ff <= csr_wdata[nsvl_pkg::SEED_CNT_W-1:0];
            end
            nsvl_pkg::CSR_POS_RAD: begin
               pos_rad_ff <= csr_wdata;
            end
            nsvl_pkg::CSR_DC_RAD: begin
               dc_rad_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- table
   always_ff @(posedge clock) begin
      if (load_wr) begin
         seed_mem_ff[wr_addr] <= wr_entry;
      end
      if (issue) begin
         seed_q_ff <= seed_mem_ff[issue_cnt_ff[IDX_W-1:0]];
      end
   end

   nsvl_dist u_dist (
      .clock   (clock),
      .reset   (reset),
      .ctl_in  (dist_ctl_in),
      .seed    (seed_q_ff),
      .pt_x    (pt_x_ff),
      .pt_y    (pt_y_ff),
      .pt_z    (pt_z_ff),
      .ctl_out (dist_ctl),
      .dist_sq (dist_sq)
   );

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (voxel_accept) begin
               state_in = (n_in == '0) ? ST_DECIDE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (dist_ctl.vld && dist_ctl.last) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ctl_ff    <= '0;
         issue_cnt_ff <= '0;
         best_vld_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_ctl_ff <= rd_ctl_in;
         if (voxel_accept) begin
            issue_cnt_ff <= '0;
            best_vld_ff  <= 1'b0;
         end else begin
            if (issue) begin
               issue_cnt_ff <= issue_cnt_ff + 1'b1;
            end
            if (take) begin
               best_vld_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (voxel_accept) begin
         n_ff    <= n_in;
         pt_x_ff <= req_ch.coord_x;
         pt_y_ff <= req_ch.coord_y;
         pt_z_ff <= req_ch.coord_z;
         last_ff <= req_ch.slice_last;
      end
      if (take) begin
         best_d_ff    <= dist_sq;
         best_true_ff <= dist_ctl.is_true;
      end
   end

   // ---------------------------------------------------------------- decide
   always_comb begin
      near  = best_vld_ff && ({2'b00, best_d_ff} < pos_rad_ff);
      in_dc = best_vld_ff && ({2'b00, best_d_ff} < dc_rad_ff);
      if (near) begin
         label_in = best_true_ff ? nsvl_pkg::LABEL_POS : nsvl_pkg::LABEL_BG;
      end else if (in_dc) begin
         label_in = best_true_ff ? nsvl_pkg::LABEL_DC : nsvl_pkg::LABEL_BG;
      end else begin
         label_in = nsvl_pkg::LABEL_BG;
      end
      // an empty table counts nothing
      one_inc  = best_vld_ff && (label_in == nsvl_pkg::LABEL_POS);
      zero_inc = best_vld_ff && (label_in == nsvl_pkg::LABEL_BG);
      one_cnt_in  = (one_inc && (32'(one_cnt_ff) < MAX_SLICE_VOXELS))
                    ? one_cnt_ff + 1'b1 : one_cnt_ff;
      zero_cnt_in = (zero_inc && (32'(zero_cnt_ff) < MAX_SLICE_VOXELS))
                    ? zero_cnt_ff + 1'b1 : zero_cnt_ff;
      hit_in = hit_ff | near;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_cnt_ff <= '0;
         one_cnt_ff  <= '0;
         hit_ff      <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (finish) begin
            rsp_vld_ff <= 1'b1;
            if (last_ff) begin
               zero_cnt_ff <= '0;
               one_cnt_ff  <= '0;
               hit_ff      <= 1'b0;
            end else begin
               zero_cnt_ff <= zero_cnt_in;
               one_cnt_ff  <= one_cnt_in;
               hit_ff      <= hit_in;
            end
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         label_ff   <= label_in;
         near_ff    <= near;
         done_ff    <= last_ff;
         kept_ff    <= last_ff && hit_in;
         neg_cnt_ff <= last_ff ? nsvl_pkg::SLICE_CNT_W'(zero_cnt_in) : '0;
         pos_cnt_ff <= last_ff ? nsvl_pkg::SLICE_CNT_W'(one_cnt_in) : '0;
      end
   end

   assign rsp_ch.valid                = rsp_vld_ff;
   assign rsp_ch.label                = label_ff;
   assign rsp_ch.near_positive        = near_ff;
   assign rsp_ch.slice_done           = done_ff;
   assign rsp_ch.slice_kept           = kept_ff;
   assign rsp_ch.slice_negative_count = neg_cnt_ff;
   assign rsp_ch.slice_positive_count = pos_cnt_ff;

   // ---------------------------------------------------------------- checks
   a_dist_in_scan: assert property (@(posedge clock) disable iff (reset)
      dist_ctl.vld |-> (state_ff == ST_SCAN))
      else $error("distance result outside of a scan");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_cnt_ff <= n_ff))
      else $error("seed read past the active count");

   a_dc_not_near: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.label == nsvl_pkg::LABEL_DC)) |-> !rsp_ch.near_positive)
      else $error("don't-care label inside the positive radius");

   a_slice_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.slice_done) |->
         (!rsp_ch.slice_kept && (rsp_ch.slice_negative_count == '0)
          && (rsp_ch.slice_positive_count == '0)))
      else $error("slice summary on an item that does not close a slice");

   a_voxel_busy: assert property (@(posedge clock) disable iff (reset)
      voxel_accept |=> !req_ch.ready)
      else $error("new item taken while a voxel is in work");

endmodule

// ===== hdl/nsvl_dist.sv =====
// ----------------------------------------------------------------------------
// nsvl_dist
// Squared-distance unit: one seed per cycle, two register stages
// (squares, then their sum).
// ----------------------------------------------------------------------------
module nsvl_dist (
   input  logic                                clock,
   input  logic                                reset,
   input  nsvl_pkg::pipe_ctl_type              ctl_in,
   input  nsvl_pkg::seed_entry_type            seed,
   input  logic signed [nsvl_pkg::COORD_W-1:0] pt_x,
   input  logic signed [nsvl_pkg::COORD_W-1:0] pt_y,
   input  logic signed [nsvl_pkg::COORD_W-1:0] pt_z,
   output nsvl_pkg::pipe_ctl_type              ctl_out,
   output logic [nsvl_pkg::DIST_W-1:0]         dist_sq
);

   logic signed [nsvl_pkg::DIFF_W-1:0] dx, dy, dz;
   logic [nsvl_pkg::DIFF_W-1:0]        ax, ay, az;
   logic [2*nsvl_pkg::DIFF_W-1:0]      px, py, pz;
   logic [nsvl_pkg::SQ_W-1:0]          sq_x_in, sq_y_in, sq_z_in;
   logic [nsvl_pkg::SQ_W-1:0]          sq_x_ff, sq_y_ff, sq_z_ff;
   logic [nsvl_pkg::DIST_W-1:0]        dist_in, dist_ff;
   nsvl_pkg::pipe_ctl_type             ctl1_ff, ctl2_ff;

   always_comb begin
      dx = nsvl_pkg::DIFF_W'(seed.x) - nsvl_pkg::DIFF_W'(pt_x);
      dy = nsvl_pkg::DIFF_W'(seed.y) - nsvl_pkg::DIFF_W'(pt_y);
      dz = nsvl_pkg::DIFF_W'(seed.z) - nsvl_pkg::DIFF_W'(pt_z);
      ax = dx[nsvl_pkg::DIFF_W-1] ? nsvl_pkg::DIFF_W'(-dx) : nsvl_pkg::DIFF_W'(dx);
      ay = dy[nsvl_pkg::DIFF_W-1] ? nsvl_pkg::DIFF_W'(-dy) : nsvl_pkg::DIFF_W'(dy);
      az = dz[nsvl_pkg::DIFF_W-1] ? nsvl_pkg::DIFF_W'(-dz) : nsvl_pkg::DIFF_W'(dz);
      px = ax * ax;
      py = ay * ay;
      pz = az * az;
      // magnitude is at most 2^20, so the square fits in 41 bits
      sq_x_in = px[nsvl_pkg::SQ_W-1:0];
      sq_y_in = py[nsvl_pkg::SQ_W-1:0];
      sq_z_in = pz[nsvl_pkg::SQ_W-1:0];
      dist_in = nsvl_pkg::DIST_W'(sq_x_ff) + nsvl_pkg::DIST_W'(sq_y_ff)
              + nsvl_pkg::DIST_W'(sq_z_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
      end else begin
         ctl1_ff <= ctl_in;
         ctl2_ff <= ctl1_ff;
      end
   end

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sq_z_ff <= sq_z_in;
      dist_ff <= dist_in;
   end

   assign ctl_out = ctl2_ff;
   assign dist_sq = dist_ff;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for nearest_seed_voxel_labeler. Seed loads and voxel
// items go in over the request channel. A scoreboard keeps its own seed table,
// registers and slice tallies, predicts each voxel's label and slice summary,
// and compares every result field by field. The run covers directed corner
// items, then random phases with varied seed counts, radii and flow control.
// ----------------------------------------------------------------------------
module tb;

   localparam int SEED_SLOTS      = 16;
   localparam int SLICE_VOXEL_CAP = 262144;
   localparam int RESET_CYCLES    = 10;
   localparam int SETTLE_CYCLES   = 24;      // longer than one voxel with a full table
   localparam int LONG_HOLD       = 400;
   localparam int CYCLE_LIMIT     = 600000;
   localparam logic [nsvl_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic                                kind;
      logic signed [nsvl_pkg::COORD_W-1:0] x;
      logic signed [nsvl_pkg::COORD_W-1:0] y;
      logic signed [nsvl_pkg::COORD_W-1:0] z;
      logic [nsvl_pkg::SLOT_W-1:0]         slot;
      logic                                seed_true;
      logic                                slice_last;
   } labeler_request_type;

   typedef struct packed {
      logic signed [1:0]                label;
      logic                             near_positive;
      logic                             slice_done;
      logic                             slice_kept;
      logic [nsvl_pkg::SLICE_CNT_W-1:0] negative_count;
      logic [nsvl_pkg::SLICE_CNT_W-1:0] positive_count;
   } label_result_type;

   class label_book;
      logic signed [nsvl_pkg::COORD_W-1:0] seed_x [SEED_SLOTS];
      logic signed [nsvl_pkg::COORD_W-1:0] seed_y [SEED_SLOTS];
      logic signed [nsvl_pkg::COORD_W-1:0] seed_z [SEED_SLOTS];
      bit                                  seed_is_true [SEED_SLOTS];
      logic [nsvl_pkg::SEED_CNT_W-1:0]     seed_count = '0;
      logic [nsvl_pkg::RAD_W-1:0]          pos_rad_sq = nsvl_pkg::POS_RAD_RESET;
      logic [nsvl_pkg::RAD_W-1:0]          dc_rad_sq  = nsvl_pkg::DC_RAD_RESET;
      int unsigned                         zero_count = 0;
      int unsigned                         one_count  = 0;
      bit                                  slice_hit  = 0;
      label_result_type                    pending_labels [$];
      int                                  mismatches = 0;
      int                                  results_seen = 0;
      int                                  loads_taken = 0;
      int                                  voxels_taken = 0;
      int                                  slices_closed = 0;
      int                                  slices_kept = 0;
      int                                  pos_labels = 0;
      int                                  dc_labels = 0;
      int                                  bg_labels = 0;

      function void set_register(logic [nsvl_pkg::CSR_IDX_W-1:0] idx,
                                 logic [nsvl_pkg::RAD_W-1:0] value);
         case (idx)
            nsvl_pkg::CSR_SEED_COUNT: seed_count = value[nsvl_pkg::SEED_CNT_W-1:0];
            nsvl_pkg::CSR_POS_RAD:    pos_rad_sq = value;
            nsvl_pkg::CSR_DC_RAD:     dc_rad_sq  = value;
            default: ;      // unknown index, ignored
         endcase
      endfunction

      function longint unsigned sq_distance(int s, labeler_request_type r);
         longint dx, dy, dz;
         dx = longint'(seed_x[s]) - longint'(r.x);
         dy = longint'(seed_y[s]) - longint'(r.y);
         dz = longint'(seed_z[s]) - longint'(r.z);
         return longint'(dx * dx + dy * dy + dz * dz);
      endfunction

      function int unsigned bump(int unsigned c);
         return (c < SLICE_VOXEL_CAP) ? c + 1 : c;
      endfunction

      // predicts the result of one accepted item; loads only update the table
      function void note_request(labeler_request_type r);
         label_result_type  res;
         int                n, best, i;
         longint unsigned   d, best_d;
         if (r.kind == nsvl_pkg::KIND_LOAD) begin
            seed_x[r.slot]       = r.x;
            seed_y[r.slot]       = r.y;
            seed_z[r.slot]       = r.z;
            seed_is_true[r.slot] = r.seed_true;
            loads_taken++;
            return;
         end
         voxels_taken++;
         res = '0;
         n = (seed_count > SEED_SLOTS) ? SEED_SLOTS : int'(seed_count);
         if (n > 0) begin
            best   = 0;
            best_d = 0;
            for (i = 0; i < n; i++) begin
               d = sq_distance(i, r);
               // strict compare keeps the lowest slot on ties
               if (i == 0 || d < best_d) begin
                  best   = i;
                  best_d = d;
               end
            end
            if (best_d < pos_rad_sq) begin
               res.near_positive = 1'b1;
               slice_hit         = 1'b1;
               res.label         = seed_is_true[best] ? nsvl_pkg::LABEL_POS
                                                      : nsvl_pkg::LABEL_BG;
            end else if (best_d < dc_rad_sq) begin
               res.label = seed_is_true[best] ? nsvl_pkg::LABEL_DC : nsvl_pkg::LABEL_BG;
            end else begin
               res.label = nsvl_pkg::LABEL_BG;
            end
            if (res.label == nsvl_pkg::LABEL_POS) begin
               one_count = bump(one_count);
               pos_labels++;
            end else if (res.label == nsvl_pkg::LABEL_BG) begin
               zero_count = bump(zero_count);
               bg_labels++;
            end else begin
               dc_labels++;
            end
         end
         if (r.slice_last) begin
            res.slice_done     = 1'b1;
            res.slice_kept     = slice_hit;
            res.negative_count = zero_count[nsvl_pkg::SLICE_CNT_W-1:0];
            res.positive_count = one_count[nsvl_pkg::SLICE_CNT_W-1:0];
            slices_closed++;
            if (slice_hit) slices_kept++;
            zero_count = 0;
            one_count  = 0;
            slice_hit  = 0;
         end
         pending_labels.push_back(res);
      endfunction

      task report_mismatch(string what, longint got_v, longint want_v);
         $display("MISMATCH at result %0d, %s: got %0d expected %0d",
                  results_seen, what, got_v, want_v);
         mismatches++;
      endtask

      task check_label(label_result_type got);
         label_result_type want;
         results_seen++;
         if (pending_labels.size() == 0) begin
            report_mismatch("result with nothing pending", 0, 0);
            return;
         end
         want = pending_labels.pop_front();
         if (got.label !== want.label)
            report_mismatch("label", got.label, want.label);
         if (got.near_positive !== want.near_positive)
            report_mismatch("near_positive", got.near_positive, want.near_positive);
         if (got.slice_done !== want.slice_done)
            report_mismatch("slice_done", got.slice_done, want.slice_done);
         if (got.slice_kept !== want.slice_kept)
            report_mismatch("slice_kept", got.slice_kept, want.slice_kept);
         if (got.negative_count !== want.negative_count)
            report_mismatch("slice_negative_count", got.negative_count, want.negative_count);
         if (got.positive_count !== want.positive_count)
            report_mismatch("slice_positive_count", got.positive_count, want.positive_count);
      endtask
   endclass

   logic                             clock;
   logic                             reset;
   logic                             csr_we;
   logic [nsvl_pkg::CSR_IDX_W-1:0]   csr_index;
   logic [nsvl_pkg::RAD_W-1:0]       csr_wdata;
   int                               cycle_count = 0;
   int                               gap_pct = 0;
   int                               stall_pct = 0;
   int                               rsp_hold_left = 0;
   label_book                        book = new();

   nsvl_req_if req_ch ();
   nsvl_rsp_if rsp_ch ();

   nearest_seed_voxel_labeler uut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, book.pending_labels.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // result side: check on each handshake, then pick next cycle's ready
   initial begin : result_sink
      label_result_type got;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            got.label          = rsp_ch.label;
            got.near_positive  = rsp_ch.near_positive;
            got.slice_done     = rsp_ch.slice_done;
            got.slice_kept     = rsp_ch.slice_kept;
            got.negative_count = rsp_ch.slice_negative_count;
            got.positive_count = rsp_ch.slice_positive_count;
            book.check_label(got);
         end
         if (rsp_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   function automatic labeler_request_type make_voxel(int x, int y, int z, bit last);
      labeler_request_type r;
      r            = '0;
      r.kind       = nsvl_pkg::KIND_VOXEL;
      r.x          = nsvl_pkg::COORD_W'(x);
      r.y          = nsvl_pkg::COORD_W'(y);
      r.z          = nsvl_pkg::COORD_W'(z);
      r.slice_last = last;
      return r;
   endfunction

   function automatic labeler_request_type make_load(int s, int x, int y, int z,
                                                     bit is_true);
      labeler_request_type r;
      r           = '0;
      r.kind      = nsvl_pkg::KIND_LOAD;
      r.slot      = nsvl_pkg::SLOT_W'(s);
      r.x         = nsvl_pkg::COORD_W'(x);
      r.y         = nsvl_pkg::COORD_W'(y);
      r.z         = nsvl_pkg::COORD_W'(z);
      r.seed_true = is_true;
      return r;
   endfunction

   // mostly voxels near live seeds so both radii come into play
   function automatic labeler_request_type random_request(int live_seeds);
      labeler_request_type r;
      int                  s, spot;
      r            = '0;
      r.kind       = ($urandom_range(99) < 15) ? nsvl_pkg::KIND_LOAD : nsvl_pkg::KIND_VOXEL;
      r.slot       = nsvl_pkg::SLOT_W'($urandom_range(SEED_SLOTS - 1));
      r.seed_true  = 1'($urandom_range(1));
      r.slice_last = ($urandom_range(11) == 0);
      s    = (live_seeds > 0) ? $urandom_range(live_seeds - 1) : $urandom_range(SEED_SLOTS - 1);
      spot = $urandom_range(99);
      if (spot < 15) begin
         r.x = nsvl_pkg::COORD_W'($urandom);
         r.y = nsvl_pkg::COORD_W'($urandom);
         r.z = nsvl_pkg::COORD_W'($urandom);
      end else if (r.kind == nsvl_pkg::KIND_LOAD) begin
         r.x = nsvl_pkg::COORD_W'(int'($urandom_range(4000)) - 2000);
         r.y = nsvl_pkg::COORD_W'(int'($urandom_range(4000)) - 2000);
         r.z = nsvl_pkg::COORD_W'(int'($urandom_range(4000)) - 2000);
      end else if (spot < 30) begin
         r.x = book.seed_x[s];
         r.y = book.seed_y[s];
         r.z = book.seed_z[s];
      end else begin
         r.x = nsvl_pkg::COORD_W'(int'(book.seed_x[s]) + int'($urandom_range(300)) - 150);
         r.y = nsvl_pkg::COORD_W'(int'(book.seed_y[s]) + int'($urandom_range(300)) - 150);
         r.z = nsvl_pkg::COORD_W'(int'(book.seed_z[s]) + int'($urandom_range(300)) - 150);
      end
      return r;
   endfunction

   // valid stays high across back-to-back items; it drops only in a gap or a drain
   task automatic send_request(input labeler_request_type r);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= r.kind;
      req_ch.coord_x    <= r.x;
      req_ch.coord_y    <= r.y;
      req_ch.coord_z    <= r.z;
      req_ch.slot       <= r.slot;
      req_ch.seed_true  <= r.seed_true;
      req_ch.slice_last <= r.slice_last;
      do @(posedge clock); while (!req_ch.ready);
      book.note_request(r);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (book.pending_labels.size() != 0) @(posedge clock);
      // a trailing load gives no result; let it finish too
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [nsvl_pkg::CSR_IDX_W-1:0] idx,
                            input logic [nsvl_pkg::RAD_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      book.set_register(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(int items, int seeds, logic [nsvl_pkg::RAD_W-1:0] pos_rad,
                            logic [nsvl_pkg::RAD_W-1:0] dc_rad, int send_gap,
                            int recv_stall, int hold_at, int drain_at);
      int live, k;
      drain_results();
      write_csr(nsvl_pkg::CSR_SEED_COUNT, nsvl_pkg::RAD_W'(seeds));
      write_csr(nsvl_pkg::CSR_POS_RAD, pos_rad);
      write_csr(nsvl_pkg::CSR_DC_RAD, dc_rad);
      gap_pct   = send_gap;
      stall_pct = recv_stall;
      live      = (seeds > SEED_SLOTS) ? SEED_SLOTS : seeds;
      for (k = 0; k < items; k++) begin
         if (k == hold_at) rsp_hold_left = LONG_HOLD;
         if (k == drain_at) drain_results();
         send_request(random_request(live));
      end
   endtask

   initial begin : stimulus
      logic [nsvl_pkg::RAD_W-1:0] pos_rad;
      int                         i;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= nsvl_pkg::CSR_SEED_COUNT;
      csr_wdata         <= '0;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= nsvl_pkg::KIND_LOAD;
      req_ch.coord_x    <= '0;
      req_ch.coord_y    <= '0;
      req_ch.coord_z    <= '0;
      req_ch.slot       <= '0;
      req_ch.seed_true  <= 1'b0;
      req_ch.slice_last <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty table: label 0, nothing counted, slice still closes
      send_request(make_voxel(-524288, 524287, 0, 0));
      send_request(make_voxel(524287, -524288, -1, 1));
      send_request(make_voxel(7, -7, 3, 0));

      // fill every slot before any nonzero seed count
      send_request(make_load(0, 0, 0, 0, 1));
      send_request(make_load(1, 1000, 0, 0, 0));
      send_request(make_load(2, -2000, 500, 500, 0));
      send_request(make_load(3, -2000, 500, 500, 1));   // same point as slot 2
      send_request(make_load(4, 524287, 524287, 524287, 1));
      send_request(make_load(5, -524288, -524288, -524288, 0));
      for (i = 6; i < SEED_SLOTS; i++)
         send_request(make_load(i, i * 3000 - 20000, (i * 777) % 5000, -i * 1500, i[0]));

      drain_results();
      write_csr(nsvl_pkg::CSR_SEED_COUNT, nsvl_pkg::RAD_W'(SEED_SLOTS));
      send_request(make_voxel(0, 0, 0, 0));                  // on a true seed
      send_request(make_voxel(100, 0, 0, 0));                // don't-care ring, true seed
      send_request(make_voxel(1000, 90, 0, 0));              // ring of a false seed
      send_request(make_voxel(-2000, 500, 500, 0));          // tie, lower slot is false
      send_request(make_voxel(524287, 524287, 524287, 0));
      send_request(make_voxel(-524288, -524288, -524288, 0));
      send_request(make_voxel(300000, -300000, 12345, 1));   // far from all seeds

      // random phases: seed count, radii, sender gaps, receiver stalls
      run_phase(180, 16, nsvl_pkg::POS_RAD_RESET, nsvl_pkg::DC_RAD_RESET, 0, 0, 40, -1);
      run_phase(180, 16, nsvl_pkg::POS_RAD_RESET, nsvl_pkg::DC_RAD_RESET, 65, 0, -1, -1);
      run_phase(180, 1, 44'd20000, 44'd60000, 0, 65, -1, -1);
      run_phase(180, 31, '0, '1, 15, 15, -1, -1);
      run_phase(180, 16, '1, '1, 0, 0, -1, 80);
      run_phase(180, 5, 44'd30000, 44'd10000, 65, 0, -1, -1);
      drain_results();
      write_csr(CSR_UNUSED, '1);
      run_phase(100, 0, 44'd1, '0, 0, 65, -1, -1);
      pos_rad = nsvl_pkg::RAD_W'($urandom_range(30000, 2000));
      run_phase(180, 17, pos_rad, pos_rad + nsvl_pkg::RAD_W'($urandom_range(40000)),
                15, 15, -1, -1);
      run_phase(180, 8, nsvl_pkg::POS_RAD_RESET, nsvl_pkg::DC_RAD_RESET, 0, 0, 60, -1);
      pos_rad = nsvl_pkg::RAD_W'($urandom_range(30000, 2000));
      run_phase(180, 16, pos_rad, pos_rad + nsvl_pkg::RAD_W'($urandom_range(40000)),
                15, 15, -1, -1);

      drain_results();
      if (book.pending_labels.size() != 0)
         book.report_mismatch("results never delivered", 0, book.pending_labels.size());
      $display("Covered %0d seed loads and %0d voxels over %0d slices (%0d kept).",
               book.loads_taken, book.voxels_taken, book.slices_closed, book.slices_kept);
      $display("Labels: %0d positive, %0d don't care, %0d background; %0d mismatches.",
               book.pos_labels, book.dc_labels, book.bg_labels, book.mismatches);
      if (book.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
